// ----- sv/fpisqrt_pkg.sv -----
// Shared types, constants and the seed table for the Q16 reciprocal square root.
// No dependencies; used by every module of the block.
package fpisqrt_pkg;

	localparam int unsigned XW = 32;   // operand / result width
	localparam int unsigned YW = 17;   // estimate width, holds 65536
	localparam int unsigned FW = 16;   // interpolation fraction width
	localparam int unsigned EW = 5;    // leading-one position width
	localparam int unsigned LATENCY = 6;

	localparam logic [XW-1:0] THREE_Q16 = 32'h0003_0000;
	localparam logic [EW-1:0] E_TOP = 5'd31;

	// 2^16 / sqrt(2^e)
	localparam logic [YW-1:0] RS_TAB [32] = '{
		17'd65536, 17'd46341, 17'd32768, 17'd23170, 17'd16384,
		17'd11585, 17'd8192,  17'd5793,  17'd4096,  17'd2896,
		17'd2048,  17'd1448,  17'd1024,  17'd724,   17'd512,
		17'd362,   17'd256,   17'd181,   17'd128,   17'd90,
		17'd64,    17'd45,    17'd32,    17'd23,    17'd16,
		17'd11,    17'd8,     17'd6,     17'd4,     17'd3,
		17'd2,     17'd1
	};

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

endpackage

// ----- sv/fpisqrt_seed.sv -----
// Seed estimate: leading-one detect, table read and linear interpolation.
// Three pipeline stages (s1..s3). Depends on fpisqrt_pkg.
module fpisqrt_seed import fpisqrt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [XW-1:0] operand,
	output ctl_t          ctl,
	output logic [XW-1:0] x,
	output logic [YW-1:0] y
);

	logic [EW-1:0] lead;
	ctl_t          ctl_s1, ctl_s2, ctl_s3;
	logic [XW-1:0] x_s1, x_s2, x_s3;
	logic [EW-1:0] e_s1;
	logic [XW-1:0] xn;
	logic [YW-1:0] yn;
	logic [YW-1:0] dy_full;
	logic [FW-1:0] frac_s2;
	logic [YW-1:0] y0_s2;
	logic [FW-1:0] dy_s2;
	logic [2*FW-1:0] prod;
	logic [YW-1:0] y_s3;

	always_comb begin
		lead = '0;
		for (int k = 0; k < XW; k++) begin
			if (operand[k])
				lead = EW'(k);
		end
	end

	// normalize so the leading one sits at the top; the bits under it are the fraction
	assign xn = x_s1 << (E_TOP - e_s1);
	assign yn = (e_s1 == E_TOP) ? '0 : RS_TAB[e_s1 + 5'd1];
	assign dy_full = RS_TAB[e_s1] - yn;   // table is decreasing, fits 16 bits
	assign prod = dy_s2 * frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= '{valid: in_valid, zero: (operand == '0)};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= operand;
		e_s1    <= lead;
		x_s2    <= x_s1;
		frac_s2 <= xn[XW-2 -: FW];
		y0_s2   <= RS_TAB[e_s1];
		dy_s2   <= dy_full[FW-1:0];
		x_s3    <= x_s2;
		y_s3    <= y0_s2 - {1'b0, prod[2*FW-1:FW]};
	end

	assign ctl = ctl_s3;
	assign x   = x_s3;
	assign y   = y_s3;

endmodule

// ----- sv/fpisqrt_newton.sv -----
// One Newton-Raphson step in Q16: y*(3*2^16 - x*y*y/2^16) / 2^17.
// Three pipeline stages (s4..s6), one multiplier each. Depends on fpisqrt_pkg.
module fpisqrt_newton import fpisqrt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_t          ctl,
	input  logic [XW-1:0] x,
	input  logic [YW-1:0] y,
	output logic          done,
	output logic [XW-1:0] inv_root
);

	ctl_t          ctl_s4, ctl_s5;
	logic [XW-1:0] x_s4;
	logic [YW-1:0] y_s4, y_s5;
	logic [XW-1:0] y2_s4, xy2_s5;
	logic [2*YW-1:0] sq;
	logic [2*XW-1:0] xprod;
	logic [XW-1:0] corr;
	logic [XW+YW-1:0] fprod;
	logic          done_s6;
	logic [XW-1:0] res_s6;

	assign sq    = y * y;             // low 32 bits kept: y = 65536 wraps to 0
	assign xprod = x_s4 * y2_s4;
	assign corr  = THREE_Q16 - xy2_s5; // wraps when xy2 is larger
	assign fprod = y_s5 * corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			done_s6 <= 1'b0;
		end else begin
			ctl_s4  <= ctl;
			ctl_s5  <= ctl_s4;
			done_s6 <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s4   <= x;
		y_s4   <= y;
		y2_s4  <= sq[XW-1:0];
		y_s5   <= y_s4;
		xy2_s5 <= xprod[XW+FW-1:FW];
		res_s6 <= ctl_s5.zero ? '0 : fprod[XW+YW-1:YW];
	end

	assign done     = done_s6;
	assign inv_root = res_s6;

endmodule

// ----- sv/fixed_point_inverse_sqrt.sv -----
// Top level of the Q16 reciprocal square root: seed stages then Newton stages.
// Depends on fpisqrt_pkg, fpisqrt_seed and fpisqrt_newton.
//
// Returns about 2^16/sqrt(operand) in Q16, 0 for a zero operand. A transaction
// is taken on every cycle with start high; busy is always low since the
// six-stage pipeline (leading-one detect, table read, interpolation, square,
// 32x32 product, correction multiply) moves forward every cycle. The result
// appears on inv_root with done high once the transaction has left the sixth
// stage, one result per transaction, in order. The receiver cannot stall it.
module fixed_point_inverse_sqrt import fpisqrt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [XW-1:0] operand,
	output logic          done,
	output logic [XW-1:0] inv_root
);

	ctl_t          seed_ctl;
	logic [XW-1:0] seed_x;
	logic [YW-1:0] seed_y;

	assign busy = 1'b0;

	fpisqrt_seed u_seed (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.operand  (operand),
		.ctl      (seed_ctl),
		.x        (seed_x),
		.y        (seed_y)
	);

	fpisqrt_newton u_newton (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (seed_ctl),
		.x        (seed_x),
		.y        (seed_y),
		.done     (done),
		.inv_root (inv_root)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("transaction did not complete after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching transaction");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && operand == '0) |-> ##6 (inv_root == '0))
		else $error("zero operand did not give zero");

	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		seed_ctl.valid |-> (seed_y <= 17'd65536))
		else $error("seed estimate out of range");

endmodule
